>>> rtl/cmfc_pkg.sv
// Shared types and constants for the cube map face coordinate unit.
`default_nettype none

package cmfc_pkg;

  localparam int unsigned CMFC_COMPONENT_WIDTH = 16;
  localparam int unsigned CMFC_FRACTION_BITS   = 16;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  // How a coordinate is finished: by the divider, or pinned to an end of the range.
  typedef enum logic [1:0] {
    SAT_DIV  = 2'd0,
    SAT_ZERO = 2'd1,
    SAT_ONE  = 2'd2
  } sat_t;

  typedef struct packed {
    face_t face;
    logic  zero;
    sat_t  sat_u;
    sat_t  sat_v;
  } side_t;

endpackage

`default_nettype wire

>>> rtl/cmfc_div_stage.sv
// One restoring-division stage: one quotient bit for each of the two coordinates.
`default_nettype none

module cmfc_div_stage #(
  parameter int unsigned COMPONENT_WIDTH = cmfc_pkg::CMFC_COMPONENT_WIDTH,
  parameter int unsigned FRACTION_BITS   = cmfc_pkg::CMFC_FRACTION_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       valid_in,
  input  wire cmfc_pkg::side_t            side_in,
  input  wire logic [COMPONENT_WIDTH:0]   d_in,
  input  wire logic [COMPONENT_WIDTH:0]   ru_in,
  input  wire logic [FRACTION_BITS-1:0]   qu_in,
  input  wire logic [COMPONENT_WIDTH:0]   rv_in,
  input  wire logic [FRACTION_BITS-1:0]   qv_in,
  output logic                            valid,
  output cmfc_pkg::side_t                 side,
  output logic [COMPONENT_WIDTH:0]        d,
  output logic [COMPONENT_WIDTH:0]        ru,
  output logic [FRACTION_BITS-1:0]        qu,
  output logic [COMPONENT_WIDTH:0]        rv,
  output logic [FRACTION_BITS-1:0]        qv
);
  import cmfc_pkg::*;

  logic [COMPONENT_WIDTH+1:0] ru2;
  logic [COMPONENT_WIDTH+1:0] rv2;
  logic [COMPONENT_WIDTH+1:0] d_ext;
  logic                       ge_u;
  logic                       ge_v;
  logic [COMPONENT_WIDTH+1:0] ru_sub;
  logic [COMPONENT_WIDTH+1:0] rv_sub;

  always_comb begin
    ru2    = {ru_in, 1'b0};
    rv2    = {rv_in, 1'b0};
    d_ext  = {1'b0, d_in};
    ge_u   = (ru2 >= d_ext);
    ge_v   = (rv2 >= d_ext);
    ru_sub = ge_u ? (ru2 - d_ext) : ru2;
    rv_sub = ge_v ? (rv2 - d_ext) : rv2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  // The remainder stays below the divisor, so the top bit is always zero.
  always_ff @(posedge clk) begin
    if (en) begin
      side <= side_in;
      d    <= d_in;
      ru   <= ru_sub[COMPONENT_WIDTH:0];
      rv   <= rv_sub[COMPONENT_WIDTH:0];
      qu   <= {qu_in[FRACTION_BITS-2:0], ge_u};
      qv   <= {qv_in[FRACTION_BITS-2:0], ge_v};
    end
  end

endmodule

`default_nettype wire

>>> rtl/cube_map_face_coordinate_unit.sv
// Each item passes stages 0 to 2, the divider chain and then the output register.
// Throughput: one item per cycle; a new item is taken whenever in_stall is low.
// The depth is set by the restoring divider, one quotient bit per stage for u and v.
// Each stage holds its item while the stage after it is full and stalled.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
`default_nettype none

module cube_map_face_coordinate_unit #(
  parameter int unsigned COMPONENT_WIDTH = cmfc_pkg::CMFC_COMPONENT_WIDTH,
  parameter int unsigned FRACTION_BITS   = cmfc_pkg::CMFC_FRACTION_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [COMPONENT_WIDTH-1:0] dir_x,
  input  wire logic signed [COMPONENT_WIDTH-1:0] dir_y,
  input  wire logic signed [COMPONENT_WIDTH-1:0] dir_z,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [2:0]                             face,
  output logic [FRACTION_BITS:0]                 coord_u,
  output logic [FRACTION_BITS:0]                 coord_v,
  output logic                                   zero_vector
);
  import cmfc_pkg::*;

  localparam int unsigned CW = COMPONENT_WIDTH;
  localparam int unsigned FB = FRACTION_BITS;
  localparam logic [FB:0] COORD_ONE = {1'b1, {FB{1'b0}}};

  // Stage 0: input capture.
  logic                 v0;
  logic                 en0;
  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;
  logic signed [CW-1:0] z0;

  // Stage 1: major axis and face.
  logic                 v1;
  logic                 en1;
  logic [CW-1:0]        m1;
  logic signed [CW-1:0] cu1;
  logic signed [CW-1:0] cv1;
  logic                 flip_u1;
  logic                 flip_v1;
  face_t                face1;
  logic                 zero1;

  // Stage 2: numerators and saturation.
  logic                 v2;
  logic                 en2;
  side_t                side2;
  logic [CW:0]          d2;
  logic [CW:0]          ru2;
  logic [CW:0]          rv2;

  // Divider chain, index 0 is fed by stage 2.
  logic        dv    [FB+1];
  side_t       dside [FB+1];
  logic [CW:0] dd    [FB+1];
  logic [CW:0] dru   [FB+1];
  logic [CW:0] drv   [FB+1];
  logic [FB-1:0] dqu [FB+1];
  logic [FB-1:0] dqv [FB+1];
  logic        ena   [FB+1];

  logic en_out;

  // Stage 1 logic.
  logic [CW:0]  ax_w;
  logic [CW:0]  ay_w;
  logic [CW:0]  az_w;
  logic [CW-1:0] ax;
  logic [CW-1:0] ay;
  logic [CW-1:0] az;
  logic          x_major;
  logic          y_major;
  logic [CW-1:0] m1_next;
  logic signed [CW-1:0] cu1_next;
  logic signed [CW-1:0] cv1_next;
  logic          flip_u1_next;
  logic          flip_v1_next;
  face_t         face1_next;
  logic          zero1_next;

  always_comb begin
    ax_w = x0[CW-1] ? (CW+1)'(-$signed({x0[CW-1], x0})) : {1'b0, x0};
    ay_w = y0[CW-1] ? (CW+1)'(-$signed({y0[CW-1], y0})) : {1'b0, y0};
    az_w = z0[CW-1] ? (CW+1)'(-$signed({z0[CW-1], z0})) : {1'b0, z0};
    ax = ax_w[CW-1:0];
    ay = ay_w[CW-1:0];
    az = az_w[CW-1:0];
    x_major = (ax > ay) && (ax > az);
    y_major = (ay > ax) && (ay > az);
    zero1_next = (x0 == '0) && (y0 == '0) && (z0 == '0);
    priority if (x_major) begin
      m1_next      = ax;
      cu1_next     = z0;
      cv1_next     = y0;
      flip_v1_next = 1'b0;
      if (!x0[CW-1]) begin
        face1_next   = FACE_POS_X;
        flip_u1_next = 1'b1;
      end else begin
        face1_next   = FACE_NEG_X;
        flip_u1_next = 1'b0;
      end
    end else if (y_major) begin
      m1_next      = ay;
      cu1_next     = x0;
      cv1_next     = z0;
      flip_u1_next = 1'b0;
      if (!y0[CW-1]) begin
        face1_next   = FACE_POS_Y;
        flip_v1_next = 1'b0;
      end else begin
        face1_next   = FACE_NEG_Y;
        flip_v1_next = 1'b1;
      end
    end else begin
      m1_next      = az;
      cu1_next     = x0;
      cv1_next     = y0;
      flip_v1_next = 1'b1;
      // Zero z with a tie also lands on the negative face.
      if (!z0[CW-1] && (z0 != '0)) begin
        face1_next   = FACE_POS_Z;
        flip_u1_next = 1'b0;
      end else begin
        face1_next   = FACE_NEG_Z;
        flip_u1_next = 1'b1;
      end
    end
  end

  // Stage 2 logic.
  logic signed [CW+1:0] m_ext;
  logic signed [CW+1:0] two_m;
  logic signed [CW+1:0] cu_ext;
  logic signed [CW+1:0] cv_ext;
  logic signed [CW+1:0] nu;
  logic signed [CW+1:0] nv;
  sat_t                 sat_u_next;
  sat_t                 sat_v_next;
  side_t                side2_next;

  always_comb begin
    m_ext  = $signed({2'b00, m1});
    two_m  = $signed({1'b0, m1, 1'b0});
    cu_ext = $signed({{2{cu1[CW-1]}}, cu1});
    cv_ext = $signed({{2{cv1[CW-1]}}, cv1});
    nu = flip_u1 ? (m_ext - cu_ext) : (m_ext + cu_ext);
    nv = flip_v1 ? (m_ext - cv_ext) : (m_ext + cv_ext);
    priority if (zero1 || (nu <= 0)) begin
      sat_u_next = SAT_ZERO;
    end else if (nu >= two_m) begin
      sat_u_next = SAT_ONE;
    end else begin
      sat_u_next = SAT_DIV;
    end
    priority if (zero1 || (nv <= 0)) begin
      sat_v_next = SAT_ZERO;
    end else if (nv >= two_m) begin
      sat_v_next = SAT_ONE;
    end else begin
      sat_v_next = SAT_DIV;
    end
    side2_next.face  = face1;
    side2_next.zero  = zero1;
    side2_next.sat_u = sat_u_next;
    side2_next.sat_v = sat_v_next;
  end

  // Each stage moves when it is empty or the stage after it moves.
  assign en_out   = !out_valid || !out_stall;
  assign ena[FB]  = en_out;
  assign en2      = !v2 || ena[0];
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign in_stall = !en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) begin
        v0 <= in_valid;
      end
      if (en1) begin
        v1 <= v0;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      x0 <= dir_x;
      y0 <= dir_y;
      z0 <= dir_z;
    end
    if (en1) begin
      m1      <= m1_next;
      cu1     <= cu1_next;
      cv1     <= cv1_next;
      flip_u1 <= flip_u1_next;
      flip_v1 <= flip_v1_next;
      face1   <= face1_next;
      zero1   <= zero1_next;
    end
    // Numerators are only divided when they lie strictly between zero and 2m.
    if (en2) begin
      side2 <= side2_next;
      d2    <= two_m[CW:0];
      ru2   <= nu[CW:0];
      rv2   <= nv[CW:0];
    end
  end

  assign dv[0]    = v2;
  assign dside[0] = side2;
  assign dd[0]    = d2;
  assign dru[0]   = ru2;
  assign drv[0]   = rv2;
  assign dqu[0]   = '0;
  assign dqv[0]   = '0;

  for (genvar k = 0; k < FB; k++) begin : g_div
    assign ena[k] = !dv[k+1] || ena[k+1];

    cmfc_div_stage #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH),
      .FRACTION_BITS   (FRACTION_BITS)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (ena[k]),
      .valid_in (dv[k]),
      .side_in  (dside[k]),
      .d_in     (dd[k]),
      .ru_in    (dru[k]),
      .qu_in    (dqu[k]),
      .rv_in    (drv[k]),
      .qv_in    (dqv[k]),
      .valid    (dv[k+1]),
      .side     (dside[k+1]),
      .d        (dd[k+1]),
      .ru       (dru[k+1]),
      .qu       (dqu[k+1]),
      .rv       (drv[k+1]),
      .qv       (dqv[k+1])
    );
  end

  // Output register.
  logic [FB:0] coord_u_next;
  logic [FB:0] coord_v_next;

  always_comb begin
    unique case (dside[FB].sat_u)
      SAT_DIV:  coord_u_next = {1'b0, dqu[FB]};
      SAT_ONE:  coord_u_next = COORD_ONE;
      default:  coord_u_next = '0;
    endcase
    unique case (dside[FB].sat_v)
      SAT_DIV:  coord_v_next = {1'b0, dqv[FB]};
      SAT_ONE:  coord_v_next = COORD_ONE;
      default:  coord_v_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= dv[FB];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      face        <= dside[FB].face;
      coord_u     <= coord_u_next;
      coord_v     <= coord_v_next;
      zero_vector <= dside[FB].zero;
    end
  end

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_vector |->
      (face == FACE_NEG_Z) && (coord_u == '0) && (coord_v == '0))
    else $error("zero vector result is not -Z with zero coordinates");

  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (coord_u <= COORD_ONE) && (coord_v <= COORD_ONE))
    else $error("face coordinate above 1.0");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (face <= FACE_NEG_Z))
    else $error("face code out of range");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v0 && v1 && v2)
    else $error("input stalled while the front stages have room");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !v0)
    else $error("valid bits not cleared by reset");

endmodule

`default_nettype wire
